>>> design/f2c_pkg.sv
// Shared constants and types for the Frenet-to-Cartesian waypoint converter.
package f2c_pkg;
	localparam int MAX_WAYPOINTS_DEF = 256;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int UNIT_SHIFT = 30;
	localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032874;
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_QUERY = 1'b1;
	localparam int COUNT_W = 9;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd2;

	typedef struct packed {
		logic [30:0] s;
		logic signed [31:0] x;
		logic signed [31:0] y;
	} waypoint_t;
endpackage

>>> design/f2c_table.sv
// Waypoint table memory: one write port, one registered read port.
module f2c_table #(
	parameter int MAX_WAYPOINTS = f2c_pkg::MAX_WAYPOINTS_DEF,
	parameter int AW = $clog2(MAX_WAYPOINTS)
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  f2c_pkg::waypoint_t  wdata,
	input  logic [AW-1:0]       raddr,
	output f2c_pkg::waypoint_t  rdata
);
	import f2c_pkg::*;

	waypoint_t mem [MAX_WAYPOINTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> design/f2c_cordic.sv
// Iterative CORDIC unit: vectoring on the segment delta, then rotation of a unit vector.
module f2c_cordic #(
	parameter int CORDIC_STEPS = f2c_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [32:0]  dx,
	input  logic signed [32:0]  dy,
	output logic                done,
	output logic signed [33:0]  cos_o,
	output logic signed [33:0]  sin_o
);
	import f2c_pkg::*;

	localparam int SW = $clog2(CORDIC_STEPS + 1);
	localparam logic [1:0] C_IDLE = 2'd0, C_VEC = 2'd1, C_ROT = 2'd2;

	logic [1:0] st_q;
	logic [SW-1:0] i_q;
	logic [CORDIC_STEPS-1:0] dir_q;
	logic flip_q;
	logic signed [35:0] x_q, y_q;
	logic signed [35:0] xs, ys;
	logic d;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign d = (y_q >= 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
				C_IDLE: begin
					if (start) begin
						if (dx == 0 && dy == 0) begin
							done <= 1'b1;
						end else begin
							flip_q <= dx < 0;
							x_q <= (dx < 0) ? -36'(dx) : 36'(dx);
							y_q <= (dx < 0) ? -36'(dy) : 36'(dy);
							i_q <= '0;
							st_q <= C_VEC;
						end
					end
				end
				C_VEC: begin
					dir_q[i_q[$clog2(CORDIC_STEPS)-1:0]] <= d;
					x_q <= d ? x_q + ys : x_q - ys;
					y_q <= d ? y_q - xs : y_q + xs;
					if (i_q == SW'(CORDIC_STEPS - 1)) begin
						i_q <= '0;
						x_q <= 36'(INV_GAIN_Q30);
						y_q <= '0;
						st_q <= C_ROT;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				C_ROT: begin
					if (dir_q[i_q[$clog2(CORDIC_STEPS)-1:0]]) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
					end
					if (i_q == SW'(CORDIC_STEPS - 1)) begin
						st_q <= C_IDLE;
						done <= 1'b1;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

	logic signed [35:0] fx, fy;
	always_comb begin
		fx = 36'(0);
		fy = 36'(0);
		if (dir_q[CORDIC_STEPS-1]) begin
			fx = x_q - ys;
			fy = y_q + xs;
		end else begin
			fx = x_q + ys;
			fy = y_q - xs;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == C_IDLE && start && dx == 0 && dy == 0) begin
			cos_o <= 34'sd1 <<< UNIT_SHIFT;
			sin_o <= '0;
		end else if (st_q == C_ROT && i_q == SW'(CORDIC_STEPS - 1)) begin
			cos_o <= flip_q ? -34'(fx) : 34'(fx);
			sin_o <= flip_q ? -34'(fy) : 34'(fy);
		end
	end
endmodule

>>> design/frenet_to_cartesian_waypoints.sv
// Top level of the Frenet-to-Cartesian waypoint converter.
// A load item is written to the table when accepted and gives no result; the next item can
// follow at once. A query item gives one result, and the next item can be accepted once that
// result is in the output register. The segment search takes K steps: zero when the query
// is not above the s of entry 0, otherwise the start index found plus one, at most the
// waypoint count clamped to the range 2 to MAX_WAYPOINTS. A segment whose two ends coincide
// skips the CORDIC passes. The segment search reads one table entry per step, the CORDIC
// unit runs one micro-rotation a cycle, and the final sums use one 34x34 multiplier for
// four products. One item is in work at a time; a finished result waits in the output
// register while the next item is accepted, and a second result waits in work until the
// first one is taken.
module frenet_to_cartesian_waypoints #(
	parameter int MAX_WAYPOINTS = f2c_pkg::MAX_WAYPOINTS_DEF,
	parameter int CORDIC_STEPS = f2c_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [8:0]          cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                mode,
	input  logic [7:0]          wp_index,
	input  logic [30:0]         wp_s,
	input  logic signed [31:0]  wp_x,
	input  logic signed [31:0]  wp_y,
	input  logic [30:0]         query_s,
	input  logic signed [31:0]  query_d,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  pos_x,
	output logic signed [31:0]  pos_y,
	output logic [7:0]          segment_index
);
	import f2c_pkg::*;

	localparam int AW = $clog2(MAX_WAYPOINTS);
	localparam int PW = AW + 1;
	localparam logic [3:0] S_IDLE = 4'd0, S_RD0 = 4'd1, S_CMP = 4'd2, S_RDQ = 4'd3,
		S_GETQ = 4'd4, S_GETP = 4'd5, S_CORD = 4'd6, S_WAIT = 4'd7, S_MUL = 4'd8,
		S_SUM = 4'd9, S_OUT = 4'd10, S_RDP = 4'd11;

	logic [3:0] st_q;
	logic [COUNT_W-1:0] count_q;
	logic [PW-1:0] n_eff, p_q, q_idx;
	logic [30:0] qs_q;
	logic signed [31:0] qd_q;
	waypoint_t rd, wp_p_q, wp_q_q;
	logic [AW-1:0] raddr;
	logic we;
	logic cstart, cdone;
	logic signed [33:0] c_q, s_q, cos_w, sin_w;
	logic [1:0] mi_q;
	logic signed [33:0] ma, mb;
	logic signed [67:0] prod_q;
	logic signed [69:0] ax_q, ay_q;
	logic signed [32:0] seg;

	always_comb begin
		if (count_q < COUNT_W'(2)) n_eff = PW'(2);
		else if (32'(count_q) > MAX_WAYPOINTS) n_eff = PW'(MAX_WAYPOINTS);
		else n_eff = PW'(count_q);
	end

	assign q_idx = (p_q + 1'b1 < n_eff) ? p_q + 1'b1 : '0;
	assign in_ready = (st_q == S_IDLE);
	assign we = in_valid && in_ready && mode == MODE_LOAD && 32'(wp_index) < MAX_WAYPOINTS;

	always_comb begin
		case (st_q)
			S_RDQ: raddr = q_idx[AW-1:0];
			S_GETQ: raddr = p_q[AW-1:0];
			S_CMP: raddr = (p_q + 1'b1 < n_eff) ? AW'(p_q + 1'b1) : AW'(p_q);
			default: raddr = AW'(0);
		endcase
	end

	f2c_table #(.MAX_WAYPOINTS(MAX_WAYPOINTS), .AW(AW)) u_table (
		.clk(clk), .we(we), .waddr(AW'(wp_index)),
		.wdata(waypoint_t'{s: wp_s, x: wp_x, y: wp_y}), .raddr(raddr), .rdata(rd)
	);

	assign cstart = (st_q == S_CORD);
	f2c_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cstart),
		.dx(33'(wp_q_q.x) - 33'(wp_p_q.x)), .dy(33'(wp_q_q.y) - 33'(wp_p_q.y)),
		.done(cdone), .cos_o(cos_w), .sin_o(sin_w)
	);

	assign seg = 33'(qs_q) - 33'(wp_p_q.s);

	always_comb begin
		case (mi_q)
			2'd0: begin ma = 34'(seg); mb = c_q; end
			2'd1: begin ma = 34'(qd_q); mb = s_q; end
			2'd2: begin ma = 34'(seg); mb = s_q; end
			default: begin ma = 34'(qd_q); mb = c_q; end
		endcase
	end

	function automatic logic signed [31:0] rsat(input logic signed [69:0] v);
		logic signed [69:0] r;
		r = (v + (70'sd1 <<< (UNIT_SHIFT - 1))) >>> UNIT_SHIFT;
		if (r > 70'sd2147483647) return 32'sh7fffffff;
		if (r < -70'sd2147483648) return 32'sh80000000;
		return r[31:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			count_q <= COUNT_RESET;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) count_q <= cfg_wdata;
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (st_q)
				S_IDLE: if (in_valid && in_ready && mode == MODE_QUERY) begin
					qs_q <= query_s;
					qd_q <= query_d;
					p_q <= '0;
					st_q <= S_RD0;
				end
				S_RD0: st_q <= S_RDP;
				S_RDP: begin
					if (qs_q > rd.s) st_q <= S_CMP;
					else st_q <= S_RDQ;
				end
				S_CMP: st_q <= S_WAIT;
				S_WAIT: begin
					if (p_q + 1'b1 < n_eff && qs_q > rd.s) begin
						p_q <= p_q + 1'b1;
						st_q <= S_CMP;
					end else begin
						st_q <= S_RDQ;
					end
				end
				S_RDQ: st_q <= S_GETQ;
				S_GETQ: begin
					wp_q_q <= rd;
					st_q <= S_GETP;
				end
				S_GETP: begin
					wp_p_q <= rd;
					st_q <= S_CORD;
				end
				S_CORD: st_q <= S_MUL;
				S_MUL: begin
					if (cdone) begin
						c_q <= cos_w;
						s_q <= sin_w;
						mi_q <= 2'd0;
						ax_q <= 70'(wp_p_q.x) <<< UNIT_SHIFT;
						ay_q <= 70'(wp_p_q.y) <<< UNIT_SHIFT;
						st_q <= S_SUM;
					end
				end
				S_SUM: begin
					prod_q <= ma * mb;
					if (mi_q != 2'd0) begin
						case (mi_q)
							2'd1: ax_q <= ax_q + 70'(prod_q);
							2'd2: ax_q <= ax_q + 70'(prod_q);
							default: ay_q <= ay_q + 70'(prod_q);
						endcase
					end
					if (mi_q == 2'd3) st_q <= S_OUT;
					mi_q <= mi_q + 1'b1;
				end
				S_OUT: begin
					if (!out_valid || out_ready) begin
						pos_x <= rsat(ax_q);
						pos_y <= rsat(ay_q - 70'(prod_q));
						segment_index <= 8'(p_q);
						out_valid <= 1'b1;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> design/f2c_checker.sv
// Port-level assertions for the waypoint converter, bound to the top level.
module f2c_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic mode,
	input logic out_valid,
	input logic out_ready,
	input logic [7:0] segment_index
);
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !mode && !out_valid |=> !out_valid)
		else $error("load item produced a result");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(segment_index))
		else $error("result dropped or changed while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode |=> !in_ready)
		else $error("query accepted while another was in work");
endmodule

bind frenet_to_cartesian_waypoints f2c_checker u_f2c_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
	.out_valid(out_valid), .out_ready(out_ready), .segment_index(segment_index)
);

>>> tb/tb_top.sv
// Self-checking testbench for the Frenet-to-Cartesian waypoint converter.
`timescale 1ns / 100ps

module tb_top;
	import f2c_pkg::*;

	typedef struct {
		logic        mode;
		logic [7:0]  idx;
		logic [30:0] s;
		logic [31:0] x;
		logic [31:0] y;
		logic [30:0] qs;
		logic [31:0] qd;
	} map_item_t;

	typedef struct {
		logic [31:0] px;
		logic [31:0] py;
		logic [7:0]  seg;
	} position_t;

	localparam int STRIDE = 1 << 22;
	localparam int STALL_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [8:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic mode = 1'b0;
	logic [7:0] wp_index = '0;
	logic [30:0] wp_s = '0;
	logic signed [31:0] wp_x = '0;
	logic signed [31:0] wp_y = '0;
	logic [30:0] query_s = '0;
	logic signed [31:0] query_d = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [7:0] segment_index;

	map_item_t pending_items[$];
	position_t expected_positions[$];
	map_item_t cur_item;

	logic [30:0] map_s[256];
	logic signed [31:0] map_x[256];
	logic signed [31:0] map_y[256];
	logic [8:0] active_count = COUNT_RESET;

	int errors = 0;
	int accepted = 0;
	int in_gap = 0;
	int out_gap = 0;
	int hold_cnt = 0;
	bit hold_done = 0;
	logic calm = 1'b0;
	int quiet_cycles = 0;

	frenet_to_cartesian_waypoints uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode), .wp_index(wp_index),
		.wp_s(wp_s), .wp_x(wp_x), .wp_y(wp_y), .query_s(query_s), .query_d(query_d),
		.out_valid(out_valid), .out_ready(out_ready), .pos_x(pos_x), .pos_y(pos_y),
		.segment_index(segment_index)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint fshift(longint v, int k);
		return v >>> k;
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic void segment_heading(input longint dx, input longint dy,
			output longint c, output longint s);
		bit dir[CORDIC_STEPS_DEF];
		bit flip;
		longint x, y, rx, ry, t;
		flip = 0;
		x = dx;
		y = dy;
		if (dx == 0 && dy == 0) begin
			c = 64'sd1 << UNIT_SHIFT;
			s = 0;
			return;
		end
		if (x < 0) begin
			x = -x;
			y = -y;
			flip = 1;
		end
		for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
			dir[i] = (y >= 0);
			if (dir[i]) begin
				t = x + fshift(y, i);
				y = y - fshift(x, i);
			end else begin
				t = x - fshift(y, i);
				y = y + fshift(x, i);
			end
			x = t;
		end
		rx = longint'(INV_GAIN_Q30);
		ry = 0;
		for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
			if (dir[i]) begin
				t = rx - fshift(ry, i);
				ry = ry + fshift(rx, i);
			end else begin
				t = rx + fshift(ry, i);
				ry = ry - fshift(rx, i);
			end
			rx = t;
		end
		if (flip) begin
			rx = -rx;
			ry = -ry;
		end
		c = rx;
		s = ry;
	endfunction

	function automatic void apply_item(map_item_t it);
		int n, p, q;
		longint c, s, seg, d, ax, ay;
		position_t r;
		if (it.mode == MODE_LOAD) begin
			map_s[it.idx] = it.s;
			map_x[it.idx] = it.x;
			map_y[it.idx] = it.y;
			return;
		end
		n = active_count;
		if (n < 2)
			n = 2;
		if (n > MAX_WAYPOINTS_DEF)
			n = MAX_WAYPOINTS_DEF;
		p = 0;
		if (it.qs > map_s[0])
			while (p + 1 < n && it.qs > map_s[p + 1])
				p++;
		q = (p + 1 < n) ? p + 1 : 0;
		segment_heading(longint'(map_x[q]) - longint'(map_x[p]),
			longint'(map_y[q]) - longint'(map_y[p]), c, s);
		seg = longint'({1'b0, it.qs}) - longint'({1'b0, map_s[p]});
		d = longint'($signed(it.qd));
		ax = (longint'(map_x[p]) <<< UNIT_SHIFT) + seg * c + d * s;
		ay = (longint'(map_y[p]) <<< UNIT_SHIFT) + seg * s - d * c;
		ax = fshift(ax + (64'sd1 << (UNIT_SHIFT - 1)), UNIT_SHIFT);
		ay = fshift(ay + (64'sd1 << (UNIT_SHIFT - 1)), UNIT_SHIFT);
		r.px = clamp32(ax);
		r.py = clamp32(ay);
		r.seg = p[7:0];
		expected_positions = {expected_positions, r};
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				apply_item(cur_item);
				accepted++;
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_items.size() == 0) begin
					in_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 7) == 0) begin
					in_gap = $urandom_range(1, 10);
					in_valid <= 1'b0;
				end else begin
					cur_item = pending_items.pop_front();
					mode <= cur_item.mode;
					wp_index <= cur_item.idx;
					wp_s <= cur_item.s;
					wp_x <= cur_item.x;
					wp_y <= cur_item.y;
					query_s <= cur_item.qs;
					query_d <= cur_item.qd;
					in_valid <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		position_t w;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_positions.size() == 0) begin
					$display("unexpected result at %0t", $time);
					errors++;
				end else begin
					w = expected_positions.pop_front();
					if (pos_x !== w.px)
						report_mismatch("pos_x", pos_x, w.px);
					if (pos_y !== w.py)
						report_mismatch("pos_y", pos_y, w.py);
					if (segment_index !== w.seg)
						report_mismatch("segment_index", {24'd0, segment_index}, {24'd0, w.seg});
				end
			end
			if (!hold_done && accepted >= 300) begin
				hold_done = 1;
				hold_cnt = 400;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_gap = $urandom_range(1, 10);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(pending_items.size() == 0 && !in_valid && expected_positions.size() == 0))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[frenet_to_cartesian_waypoints] ERROR");
			$finish;
		end
	end

	task automatic push_load(int idx, logic [30:0] s, logic [31:0] x, logic [31:0] y);
		map_item_t it;
		it.mode = MODE_LOAD;
		it.idx = idx[7:0];
		it.s = s;
		it.x = x;
		it.y = y;
		it.qs = 31'($urandom());
		it.qd = $urandom();
		pending_items = {pending_items, it};
	endtask

	task automatic push_query(logic [30:0] qs, logic [31:0] qd);
		map_item_t it;
		it.mode = MODE_QUERY;
		it.idx = 8'($urandom());
		it.s = 31'($urandom());
		it.x = $urandom();
		it.y = $urandom();
		it.qs = qs;
		it.qd = qd;
		pending_items = {pending_items, it};
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_positions.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic set_count(logic [8:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		active_count = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] coord();
		if ($urandom_range(0, 4) == 0)
			return $urandom();
		return $urandom_range(0, 1 << 25) - (1 << 24);
	endfunction

	task automatic random_phase(logic [8:0] cnt, int loads, int queries, bit last);
		int n, idx, span;
		logic [30:0] s;
		logic [31:0] d;
		if (last)
			calm <= 1'b1;
		set_count(cnt);
		n = (cnt < 2) ? 2 : (cnt > 256) ? 256 : cnt;
		for (int i = 0; i < loads; i++) begin
			idx = $urandom_range(0, n - 1);
			if ($urandom_range(0, 4) == 0)
				s = 31'($urandom());
			else
				s = 31'(idx * STRIDE + $urandom_range(0, STRIDE - 1));
			push_load(idx, s, coord(), coord());
		end
		span = n * STRIDE;
		for (int i = 0; i < queries; i++) begin
			if ($urandom_range(0, 4) == 0)
				s = 31'($urandom());
			else
				s = 31'($urandom_range(0, span - 1));
			if ($urandom_range(0, 5) == 0)
				d = $urandom();
			else
				d = $urandom_range(0, 1 << 21) - (1 << 20);
			push_query(s, d);
		end
		drain();
	endtask

	initial begin
		logic [8:0] counts[10];
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < 256; i++)
			push_load(i, 31'(i * STRIDE + $urandom_range(0, STRIDE - 1)), coord(), coord());
		drain();

		set_count(9'd2);
		push_load(0, 31'd100 << 16, 32'd0, 32'd0);
		push_load(1, 31'd200 << 16, 32'd10 << 16, 32'd0);
		push_query(31'd0, 32'd0);
		push_query(31'd100 << 16, 32'd3 << 16);
		push_query(31'd150 << 16, 32'h7fffffff);
		push_query(31'd150 << 16, 32'h80000000);
		push_query(31'h7fffffff, 32'd0);
		push_query(31'h7fffffff, 32'h80000000);
		push_load(1, 31'd200 << 16, 32'd0, 32'd0);
		push_query(31'd120 << 16, 32'd5 << 16);
		push_load(0, 31'd0, 32'h7fffffff, 32'h80000000);
		push_load(1, 31'h7fffffff, 32'h80000000, 32'h7fffffff);
		push_query(31'h40000000, 32'h7fffffff);
		push_query(31'h7fffffff, 32'h80000000);
		push_query(31'd0, 32'h7fffffff);
		push_load(0, 31'd50 << 16, 32'hffff0000, 32'd7 << 16);
		push_load(1, 31'd60 << 16, 32'hfff00000, 32'hfff00000);
		push_query(31'd55 << 16, 32'hfffe0000);
		push_query(31'd10 << 16, 32'd1 << 16);
		drain();

		counts = '{9'd3, 9'd256, 9'd0, 9'd511, 9'd8, 9'd1, 9'd300, 9'd16, 9'd2, 9'd2};
		counts[8] = 9'($urandom_range(2, 40));
		for (int ph = 0; ph < 10; ph++) begin
			if (counts[ph] >= 256)
				random_phase(counts[ph], 10, 8, ph == 9);
			else
				random_phase(counts[ph], 12, 33, ph == 9);
		end

		drain();
		if (errors == 0)
			$display("[frenet_to_cartesian_waypoints] OK");
		else
			$display("[frenet_to_cartesian_waypoints] ERROR");
		$finish;
	end
endmodule

>>> sim.f
design/f2c_pkg.sv
design/f2c_table.sv
design/f2c_cordic.sv
design/frenet_to_cartesian_waypoints.sv
design/f2c_checker.sv
tb/tb_top.sv
